>>> src/pfc_pkg.sv
// Shared types, constants and command words for the PFC cascaded PI control core.
// Used by every module of the core; depends on nothing.
package pfc_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int GAIN_W        = 40;
    localparam int GAIN_HALF_W   = 20;
    localparam int INV_W         = 24;
    localparam int LIMIT_W       = 16;
    localparam int PERIOD_W      = 16;
    localparam int MAXREF_W      = 15;
    localparam int CFG_DATA_W    = 40;
    localparam int CFG_INDEX_W   = 3;

    // Datapath widths that do not depend on the fraction width.
    localparam int ERR_W   = 18;
    localparam int DERR_W  = 19;
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 62;
    localparam int NUM_W   = 33;

    localparam logic [GAIN_W-1:0]   VOLTAGE_KP_RST    = 40'd53687091;
    localparam logic [GAIN_W-1:0]   VOLTAGE_KI_TS_RST = 40'd206488;
    localparam logic [GAIN_W-1:0]   CURRENT_KP_RST    = 40'd2621440;
    localparam logic [GAIN_W-1:0]   CURRENT_KI_TS_RST = 40'd10;
    localparam logic [INV_W-1:0]    INV_PEAK_RST      = 24'd3226;
    localparam logic [LIMIT_W-1:0]  LOOP_LIMIT_RST    = 16'd50;
    localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST    = 16'd0;
    localparam logic [MAXREF_W-1:0] MAX_REF_RST       = 15'd5632;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VOLTAGE_KP    = 3'd0,
        CFG_VOLTAGE_KI_TS = 3'd1,
        CFG_CURRENT_KP    = 3'd2,
        CFG_CURRENT_KI_TS = 3'd3,
        CFG_INV_PEAK      = 3'd4,
        CFG_LOOP_LIMIT    = 3'd5,
        CFG_PWM_PERIOD    = 3'd6,
        CFG_MAX_REF       = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic        [14:0] bus_voltage_ref;
        logic signed [15:0] bus_voltage_meas;
        logic signed [15:0] ac_voltage;
        logic signed [15:0] ac_current;
    } in_word_t;

    typedef struct packed {
        logic        [15:0] duty_count;
        logic        [14:0] peak_current_ref;
        logic signed [15:0] shaped_current_ref;
    } out_word_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_FF,
        MUL_KP_LO,
        MUL_KP_HI,
        MUL_KI_LO,
        MUL_KI_HI,
        MUL_PEAK_VAC,
        MUL_SHAPE
    } mul_op_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_FF_NUM,
        ACC_INIT,
        ACC_ADD,
        ACC_ADD_HI,
        ACC_CLAMP,
        ACC_SHAPED,
        ACC_TOTAL
    } acc_op_t;

    typedef struct packed {
        logic    latch;
        mul_op_t mul_op;
        logic    loop_cur;
        acc_op_t acc_op;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FF,
        ST_V0,
        ST_V1,
        ST_V2,
        ST_V3,
        ST_V4,
        ST_VCLAMP,
        ST_SH0,
        ST_SH1,
        ST_SH2,
        ST_C0,
        ST_C1,
        ST_C2,
        ST_C3,
        ST_C4,
        ST_CCLAMP,
        ST_DIVWAIT,
        ST_TOTAL,
        ST_OUT
    } ctrl_state_t;

endpackage

>>> src/pfc_div.sv
// Feed-forward divider: floor(num * 2^FRAC_BITS / vref), four quotient bits per cycle,
// with sign correction and saturation. Depends on pfc_pkg.
module pfc_div #(
    parameter int FRAC_BITS = pfc_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [pfc_pkg::NUM_W-1:0] num,
    input  logic        [14:0]               vref,
    output logic                             done,
    output logic signed [FRAC_BITS+21:0]     quot
);
    import pfc_pkg::*;

    localparam int DVD_W = 32 + FRAC_BITS;
    localparam int PAD_W = ((DVD_W + 3) / 4) * 4;
    localparam int STEPS = PAD_W / 4;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int FF_W  = FRAC_BITS + 22;

    localparam logic signed [PAD_W:0] SAT_POS = (PAD_W+1)'(1) <<< (20 + FRAC_BITS);
    localparam logic signed [PAD_W:0] SAT_HI  =
        SAT_POS + ((PAD_W+1)'(1) <<< FRAC_BITS);
    localparam logic signed [PAD_W:0] SAT_NEG = -SAT_POS;

    typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIN} div_state_t;

    div_state_t              state_reg, state_next;
    logic [PAD_W-1:0]        dvd_reg, dvd_next;
    logic [PAD_W-1:0]        quo_reg, quo_next;
    logic [15:0]             rem_reg, rem_next;
    logic [14:0]             dsr_reg, dsr_next;
    logic                    neg_reg, neg_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic signed [FF_W-1:0]  quot_reg, quot_next;

    logic [NUM_W-1:0]        mag;
    logic [15:0]             rem_step;
    logic [15:0]             rem_sh;
    logic [3:0]              qbits;
    logic signed [PAD_W:0]   qs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    // Four restoring steps; the partial remainder stays below the divisor.
    always_comb begin
        rem_step = rem_reg;
        rem_sh   = '0;
        qbits    = '0;
        for (int i = 0; i < 4; i++) begin
            rem_sh = {rem_step[14:0], dvd_reg[PAD_W-1-i]};
            if (rem_sh >= {1'b0, dsr_reg}) begin
                rem_step     = rem_sh - {1'b0, dsr_reg};
                qbits[3-i]   = 1'b1;
            end else begin
                rem_step = rem_sh;
            end
        end
    end

    always_comb begin
        mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        qs  = $signed({1'b0, quo_reg});
        if (neg_reg) begin
            qs = (rem_reg != '0) ? -(qs + (PAD_W+1)'(1)) : -qs;
        end
    end

    always_comb begin
        state_next = state_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        done_next  = done_reg;
        quot_next  = quot_reg;
        if (start) begin
            dvd_next   = PAD_W'({mag[31:0], {FRAC_BITS{1'b0}}});
            quo_next   = '0;
            rem_next   = '0;
            dsr_next   = (vref == '0) ? 15'd1 : vref;
            neg_next   = num[NUM_W-1];
            cnt_next   = CNT_W'(STEPS);
            done_next  = 1'b0;
            state_next = DV_RUN;
        end else begin
            case (state_reg)
                DV_RUN: begin
                    dvd_next = dvd_reg << 4;
                    quo_next = {quo_reg[PAD_W-5:0], qbits};
                    rem_next = rem_step;
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = DV_FIN;
                    end
                end
                DV_FIN: begin
                    if (qs >= SAT_HI) begin
                        quot_next = FF_W'(SAT_POS);
                    end else if (qs < SAT_NEG) begin
                        quot_next = FF_W'(SAT_NEG);
                    end else begin
                        quot_next = FF_W'(qs);
                    end
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end
                default: begin
                    state_next = DV_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> src/pfc_dp.sv
// Datapath: configuration registers, loop state, shared multiplier and accumulator.
// Depends on pfc_pkg and pfc_div.
module pfc_dp #(
    parameter int FRAC_BITS = pfc_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [pfc_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  pfc_pkg::in_word_t                      in_word,
    input  pfc_pkg::dp_cmd_t                       cmd,
    output logic                                   div_done,
    output pfc_pkg::out_word_t                     result
);
    import pfc_pkg::*;

    localparam int CRI_W = MAXREF_W + FRAC_BITS + 1;
    localparam int CLI_W = LIMIT_W + FRAC_BITS + 2;
    localparam int FF_W  = FRAC_BITS + 22;
    localparam int TOT_W = FRAC_BITS + 23;

    logic [GAIN_W-1:0]   vkp_reg, vki_reg, ckp_reg, cki_reg;
    logic [INV_W-1:0]    inv_reg;
    logic [LIMIT_W-1:0]  lim_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [MAXREF_W-1:0] maxref_reg;

    in_word_t                  vin_reg;
    logic signed [ERR_W-1:0]   ev_reg, last_ev_reg, ei_reg, last_ei_reg, ffd_reg;
    logic signed [DERR_W-1:0]  dev_reg, dei_reg;
    logic signed [CRI_W-1:0]   cri_reg;
    logic signed [CLI_W-1:0]   cli_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [15:0]        shaped_reg;
    logic signed [TOT_W-1:0]   total_reg;

    logic signed [ERR_W-1:0]   ev_new, ei_new;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [GAIN_W-1:0]         kp_sel, ki_sel;
    logic signed [ERR_W-1:0]   err_sel;
    logic signed [DERR_W-1:0]  derr_sel;
    logic signed [ACC_W-1:0]   prod_ext, integ_ext, cri_hi, lim_hi, lim_lo;
    logic signed [PROD_W-1:0]  shape_shift;
    logic signed [15:0]        shaped_new;
    logic signed [TOT_W-1:0]   total_int;
    logic [PERIOD_W-1:0]       duty;
    logic signed [FF_W-1:0]    ff_quot;
    logic [14:0]               vref_eff;

    pfc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.acc_op == ACC_FF_NUM),
        .num     (prod_reg[NUM_W-1:0]),
        .vref    (vin_reg.bus_voltage_ref),
        .done    (div_done),
        .quot    (ff_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vkp_reg    <= VOLTAGE_KP_RST;
            vki_reg    <= VOLTAGE_KI_TS_RST;
            ckp_reg    <= CURRENT_KP_RST;
            cki_reg    <= CURRENT_KI_TS_RST;
            inv_reg    <= INV_PEAK_RST;
            lim_reg    <= LOOP_LIMIT_RST;
            period_reg <= PWM_PERIOD_RST;
            maxref_reg <= MAX_REF_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_VOLTAGE_KP:    vkp_reg    <= cfg_wdata;
                CFG_VOLTAGE_KI_TS: vki_reg    <= cfg_wdata;
                CFG_CURRENT_KP:    ckp_reg    <= cfg_wdata;
                CFG_CURRENT_KI_TS: cki_reg    <= cfg_wdata;
                CFG_INV_PEAK:      inv_reg    <= cfg_wdata[INV_W-1:0];
                CFG_LOOP_LIMIT:    lim_reg    <= cfg_wdata[LIMIT_W-1:0];
                CFG_PWM_PERIOD:    period_reg <= cfg_wdata[PERIOD_W-1:0];
                CFG_MAX_REF:       maxref_reg <= cfg_wdata[MAXREF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ev_new = ERR_W'($signed({1'b0, in_word.bus_voltage_ref}))
               - ERR_W'(in_word.bus_voltage_meas);
        // A zero reference counts as one in the feed-forward term.
        vref_eff = (in_word.bus_voltage_ref == '0) ? 15'd1 : in_word.bus_voltage_ref;
        shape_shift = prod_reg >>> FRAC_BITS;
        if (shape_shift > PROD_W'(32767)) begin
            shaped_new = 16'sd32767;
        end else if (shape_shift < -PROD_W'(32768)) begin
            shaped_new = -16'sd32768;
        end else begin
            shaped_new = 16'(shape_shift);
        end
        ei_new = ERR_W'(shaped_new) - ERR_W'(vin_reg.ac_current);
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        kp_sel   = cmd.loop_cur ? ckp_reg : vkp_reg;
        ki_sel   = cmd.loop_cur ? cki_reg : vki_reg;
        err_sel  = cmd.loop_cur ? ei_reg  : ev_reg;
        derr_sel = cmd.loop_cur ? dei_reg : dev_reg;
        mul_a    = '0;
        mul_b    = '0;
        case (cmd.mul_op)
            MUL_FF: begin
                mul_a = $signed(MUL_A_W'(period_reg));
                mul_b = MUL_B_W'(ffd_reg);
            end
            MUL_KP_LO: begin
                mul_a = $signed(MUL_A_W'(kp_sel[GAIN_HALF_W-1:0]));
                mul_b = MUL_B_W'(derr_sel);
            end
            MUL_KP_HI: begin
                mul_a = $signed(MUL_A_W'(kp_sel[GAIN_W-1:GAIN_HALF_W]));
                mul_b = MUL_B_W'(derr_sel);
            end
            MUL_KI_LO: begin
                mul_a = $signed(MUL_A_W'(ki_sel[GAIN_HALF_W-1:0]));
                mul_b = MUL_B_W'(err_sel);
            end
            MUL_KI_HI: begin
                mul_a = $signed(MUL_A_W'(ki_sel[GAIN_W-1:GAIN_HALF_W]));
                mul_b = MUL_B_W'(err_sel);
            end
            MUL_PEAK_VAC: begin
                mul_a = $signed(MUL_A_W'(cri_reg[FRAC_BITS+MAXREF_W-1:FRAC_BITS]));
                mul_b = MUL_B_W'(vin_reg.ac_voltage);
            end
            MUL_SHAPE: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = $signed(MUL_B_W'(inv_reg));
            end
            default: ;
        endcase
    end

    always_comb begin
        prod_ext  = ACC_W'(prod_reg);
        integ_ext = cmd.loop_cur ? ACC_W'(cli_reg) : ACC_W'(cri_reg);
        cri_hi    = $signed(ACC_W'({maxref_reg, {FRAC_BITS{1'b0}}}));
        lim_hi    = $signed(ACC_W'({lim_reg, {FRAC_BITS{1'b0}}}));
        lim_lo    = -lim_hi;
        total_int = total_reg >>> FRAC_BITS;
        if (total_int > $signed(TOT_W'(period_reg))) begin
            duty = period_reg;
        end else if (total_int < TOT_W'(0)) begin
            duty = '0;
        end else begin
            duty = PERIOD_W'(total_int);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_ev_reg <= '0;
            last_ei_reg <= '0;
            cri_reg     <= '0;
            cli_reg     <= '0;
        end else begin
            if (cmd.latch) begin
                last_ev_reg <= ev_new;
            end
            if (cmd.acc_op == ACC_SHAPED) begin
                last_ei_reg <= ei_new;
            end
            if (cmd.acc_op == ACC_CLAMP && !cmd.loop_cur) begin
                if (acc_reg > cri_hi) begin
                    cri_reg <= CRI_W'(cri_hi);
                end else if (acc_reg < ACC_W'(0)) begin
                    cri_reg <= '0;
                end else begin
                    cri_reg <= CRI_W'(acc_reg);
                end
            end
            if (cmd.acc_op == ACC_CLAMP && cmd.loop_cur) begin
                if (acc_reg > lim_hi) begin
                    cli_reg <= CLI_W'(lim_hi);
                end else if (acc_reg < lim_lo) begin
                    cli_reg <= CLI_W'(lim_lo);
                end else begin
                    cli_reg <= CLI_W'(acc_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            vin_reg <= in_word;
            ev_reg  <= ev_new;
            dev_reg <= DERR_W'(ev_new) - DERR_W'(last_ev_reg);
            ffd_reg <= ERR_W'($signed({1'b0, vref_eff}))
                     - ERR_W'(in_word.ac_voltage);
        end
        prod_reg <= mul_a * mul_b;
        case (cmd.acc_op)
            ACC_INIT:   acc_reg <= integ_ext + prod_ext;
            ACC_ADD:    acc_reg <= acc_reg + prod_ext;
            ACC_ADD_HI: acc_reg <= acc_reg + (prod_ext <<< GAIN_HALF_W);
            ACC_SHAPED: begin
                shaped_reg <= shaped_new;
                ei_reg     <= ei_new;
                dei_reg    <= DERR_W'(ei_new) - DERR_W'(last_ei_reg);
            end
            ACC_TOTAL:  total_reg <= TOT_W'(cli_reg) + TOT_W'(ff_quot);
            default: ;
        endcase
    end

    assign result.duty_count         = duty;
    assign result.peak_current_ref   = cri_reg[FRAC_BITS+MAXREF_W-1:FRAC_BITS];
    assign result.shaped_current_ref = shaped_reg;

endmodule

>>> src/pfc_ctrl.sv
// Sequencer for one sample: steps the shared multiplier and accumulator through
// both PI loops and the output load. Depends on pfc_pkg.
module pfc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pfc_pkg::dp_status_t   status,
    output pfc_pkg::dp_cmd_t      cmd
);
    import pfc_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_op   = MUL_NONE;
        cmd.acc_op   = ACC_NONE;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
                if (in_valid) begin
                    state_next = ST_FF;
                end
            end
            ST_FF: begin
                cmd.mul_op = MUL_FF;
                state_next = ST_V0;
            end
            // The feed-forward product is handed to the divider here.
            ST_V0: begin
                cmd.mul_op = MUL_KP_LO;
                cmd.acc_op = ACC_FF_NUM;
                state_next = ST_V1;
            end
            ST_V1: begin
                cmd.mul_op = MUL_KP_HI;
                cmd.acc_op = ACC_INIT;
                state_next = ST_V2;
            end
            ST_V2: begin
                cmd.mul_op = MUL_KI_LO;
                cmd.acc_op = ACC_ADD_HI;
                state_next = ST_V3;
            end
            ST_V3: begin
                cmd.mul_op = MUL_KI_HI;
                cmd.acc_op = ACC_ADD;
                state_next = ST_V4;
            end
            ST_V4: begin
                cmd.acc_op = ACC_ADD_HI;
                state_next = ST_VCLAMP;
            end
            ST_VCLAMP: begin
                cmd.acc_op = ACC_CLAMP;
                state_next = ST_SH0;
            end
            ST_SH0: begin
                cmd.mul_op = MUL_PEAK_VAC;
                state_next = ST_SH1;
            end
            ST_SH1: begin
                cmd.mul_op = MUL_SHAPE;
                state_next = ST_SH2;
            end
            ST_SH2: begin
                cmd.acc_op = ACC_SHAPED;
                state_next = ST_C0;
            end
            ST_C0: begin
                cmd.loop_cur = 1'b1;
                cmd.mul_op   = MUL_KP_LO;
                state_next   = ST_C1;
            end
            ST_C1: begin
                cmd.loop_cur = 1'b1;
                cmd.mul_op   = MUL_KP_HI;
                cmd.acc_op   = ACC_INIT;
                state_next   = ST_C2;
            end
            ST_C2: begin
                cmd.loop_cur = 1'b1;
                cmd.mul_op   = MUL_KI_LO;
                cmd.acc_op   = ACC_ADD_HI;
                state_next   = ST_C3;
            end
            ST_C3: begin
                cmd.loop_cur = 1'b1;
                cmd.mul_op   = MUL_KI_HI;
                cmd.acc_op   = ACC_ADD;
                state_next   = ST_C4;
            end
            ST_C4: begin
                cmd.loop_cur = 1'b1;
                cmd.acc_op   = ACC_ADD_HI;
                state_next   = ST_CCLAMP;
            end
            ST_CCLAMP: begin
                cmd.loop_cur = 1'b1;
                cmd.acc_op   = ACC_CLAMP;
                state_next   = ST_DIVWAIT;
            end
            ST_DIVWAIT: begin
                if (status.div_done) begin
                    state_next = ST_TOTAL;
                end
            end
            ST_TOTAL: begin
                cmd.acc_op = ACC_TOTAL;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/pfc_cascade_pi_control_core.sv
// Top level of the boost PFC cascaded PI control core: sequencer, datapath and
// output register. Depends on pfc_pkg, pfc_ctrl and pfc_dp.
//
//   Channel   Direction  Handshake          Word
//   s_        in         s_valid / s_ready  pfc_pkg::in_word_t  (one sample)
//   m_        out        m_valid / m_ready  pfc_pkg::out_word_t (one result)
//   cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// A result is valid once its sample has run through both loops and the feed-forward divider;
// a new sample is taken only once the result of the last one is in the output register.
// At a fraction width of 24 the feed-forward divider sets the time to a result, and the
// sequencer waits for it once the current loop is done.
// Synchronous active-low reset restores the register defaults and clears the loop state.
// A stalled result waits in the output register; the next word is taken meanwhile
// and held at its end until the output register is free.
module pfc_cascade_pi_control_core #(
    parameter int FRAC_BITS = pfc_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pfc_pkg::in_word_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pfc_pkg::out_word_t                  m_data,
    input  logic                                cfg_wr_en,
    input  logic [pfc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import pfc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    out_word_t  result;
    logic       div_done;
    logic       m_valid_reg, m_valid_next;
    out_word_t  m_data_reg;

    pfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pfc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_word   (s_data),
        .cmd       (cmd),
        .div_done  (div_done),
        .result    (result)
    );

    always_comb begin
        status.div_done = div_done;
        status.out_free = !m_valid_reg || m_ready;
        m_valid_next    = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (cmd.out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
